// ----- src/set_assoc_lru_tag_array_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative tag array
// Shared property wrappers, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_TAG_ARRAY_TOP_DEFINES_SVH
`define SET_ASSOC_LRU_TAG_ARRAY_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SATAG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SATAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/satag_pkg.sv -----
// ----------------------------------------------------------------------------
// satag_pkg
// Request kinds, register indexes, field widths and shared types of the
// set-associative LRU tag array.
// ----------------------------------------------------------------------------
package satag_pkg;

  // Field widths fixed by the request and register layout
  localparam int KIND_W       = 2;
  localparam int VM_W         = 4;
  localparam int LINE_SHIFT_W = 4;
  localparam int SET_LOG2_W   = 3;
  localparam int WAYS_CFG_W   = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 4;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ACCESS    = 2'd0,
    KIND_PROBE     = 2'd1,
    KIND_INVAL     = 2'd2,
    KIND_INVAL_ALL = 2'd3
  } kind_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_LOG2   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  // Register reset values
  localparam logic [LINE_SHIFT_W-1:0] LINE_SHIFT_RST = 4'd6;
  localparam logic [SET_LOG2_W-1:0]   SET_LOG2_RST   = 3'd6;
  localparam logic [WAYS_CFG_W-1:0]   WAYS_RST       = 3'd4;

  // Status of one lookup/update pass
  typedef struct packed {
    logic hit;    // matching valid line found
    logic write;  // set row changes and must be written back
  } upd_stat_t;

endpackage

// ----- src/satag_if.sv -----
// ----------------------------------------------------------------------------
// satag channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------

// Request channel
interface satag_in_if #(
  parameter int ADDR_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [ADDR_BITS-1:0] address;
  logic [3:0]           vm_id;

  modport source (output valid, output kind, output address, output vm_id, input ready);
  modport sink   (input valid, input kind, input address, input vm_id, output ready);
endinterface

// Result channel
interface satag_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink   (input valid, input hit, output ready);
endinterface

// Register write channel
interface satag_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [3:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- src/satag_ram.sv -----
// ----------------------------------------------------------------------------
// satag_ram
// One-write, one-read RAM with registered read data and read enable.
// ----------------------------------------------------------------------------
module satag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read returns the contents before a same-edge write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/satag_update.sv -----
// ----------------------------------------------------------------------------
// satag_update
// Tag match, victim choice and LRU rank update for one set row.
// ----------------------------------------------------------------------------
module satag_update #(
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 48,
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  satag_pkg::kind_t                         kind,
  input  logic [ADDR_BITS-1:0]                     line,
  input  logic [satag_pkg::VM_W-1:0]               vm,
  input  logic [WAYS-1:0]                          way_en,
  input  logic [WAYS-1:0]                          valid_row,
  input  logic [WAYS-1:0][ADDR_BITS-1:0]           tag_row,
  input  logic [WAYS-1:0][satag_pkg::VM_W-1:0]     vm_row,
  input  logic [WAYS-1:0][RANK_W-1:0]              rank_row,
  output logic [WAYS-1:0]                          valid_nxt,
  output logic [WAYS-1:0][ADDR_BITS-1:0]           tag_nxt,
  output logic [WAYS-1:0][satag_pkg::VM_W-1:0]     vm_nxt,
  output logic [WAYS-1:0][RANK_W-1:0]              rank_nxt,
  output satag_pkg::upd_stat_t                     stat
);

  import satag_pkg::*;

  logic [WAYS-1:0]   match;
  logic [WAYS-1:0]   found_oh;
  logic [WAYS-1:0]   free;
  logic [WAYS-1:0]   free_oh;
  logic [WAYS-1:0]   old_c;
  logic [WAYS-1:0]   old_oh;
  logic [WAYS-1:0]   tgt_oh;
  logic [RANK_W-1:0] tgt_rank;
  logic              any_hit;

  // Per-way match within the ways in use
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = way_en[w] && valid_row[w] && (tag_row[w] == line) && (vm_row[w] == vm);
    end
  end

  assign any_hit  = |match;
  assign found_oh = match & (~match + WAYS'(1));

  // Lowest free way in use
  assign free    = way_en & ~valid_row;
  assign free_oh = free & (~free + WAYS'(1));

  // Least recent way in use, lowest index on a tie
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      old_c[w] = way_en[w];
      for (int v = 0; v < WAYS; v++) begin
        if (way_en[v] && (rank_row[v] < rank_row[w])) begin
          old_c[w] = 1'b0;
        end
      end
    end
  end

  assign old_oh = old_c & (~old_c + WAYS'(1));

  // Way the request acts on
  always_comb begin
    if (kind == KIND_ACCESS && !any_hit) begin
      tgt_oh = (|free) ? free_oh : old_oh;
    end else begin
      tgt_oh = found_oh;
    end
  end

  always_comb begin
    tgt_rank = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (tgt_oh[w]) begin
        tgt_rank = rank_row[w];
      end
    end
  end

  // Row update per request kind
  always_comb begin
    valid_nxt  = valid_row;
    tag_nxt    = tag_row;
    vm_nxt     = vm_row;
    rank_nxt   = rank_row;
    stat.hit   = 1'b0;
    stat.write = 1'b0;
    case (kind)
      KIND_ACCESS: begin
        stat.hit   = any_hit;
        stat.write = 1'b1;
        // make target most recent
        for (int i = 0; i < WAYS; i++) begin
          if (tgt_oh[i]) begin
            rank_nxt[i] = RANK_W'(WAYS - 1);
          end else if (rank_row[i] > tgt_rank) begin
            rank_nxt[i] = rank_row[i] - RANK_W'(1);
          end
        end
        // fill on miss
        if (!any_hit) begin
          valid_nxt = valid_row | tgt_oh;
          for (int i = 0; i < WAYS; i++) begin
            if (tgt_oh[i]) begin
              tag_nxt[i] = line;
              vm_nxt[i]  = vm;
            end
          end
        end
      end
      KIND_PROBE: begin
        stat.hit = any_hit;
      end
      KIND_INVAL: begin
        stat.hit = any_hit;
        if (any_hit) begin
          stat.write = 1'b1;
          valid_nxt  = valid_row & ~tgt_oh;
          // make target least recent
          for (int i = 0; i < WAYS; i++) begin
            if (tgt_oh[i]) begin
              rank_nxt[i] = '0;
            end else if (rank_row[i] < tgt_rank) begin
              rank_nxt[i] = rank_row[i] + RANK_W'(1);
            end
          end
        end
      end
      default: begin
        // invalidate all is handled on the valid bits directly
        stat.hit = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/set_assoc_lru_tag_array_top.sv -----
// Set-associative tag array with VM-qualified tags and true LRU replacement.
// Takes one request per clock while the result channel is not stalled; a
// request's result enters the output register as it leaves the request stage.
// The rate is set by the single update stage that follows the tag and rank
// RAM read: each request reads its set row on acceptance and writes it back
// when it completes, and a request to the set just written takes the new
// row from a forwarding register. Valid bits and per-set rank-valid bits
// are flip-flops, so reset and invalidate-all take effect at once and there
// is no clearing pass. Registers may be written only while the block is
// idle; a geometry change should be followed by an invalidate-all.
`include "set_assoc_lru_tag_array_top_defines.svh"

// ----------------------------------------------------------------------------
// set_assoc_lru_tag_array_top
// Input stage with RAM read, row update, write-back and result register.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_array_top #(
  parameter int SETS      = 64,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  satag_in_if.sink     in_ch,
  satag_out_if.source  out_ch,
  satag_cfg_if.sink    cfg_ch
);

  import satag_pkg::*;

  localparam int SET_W        = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_LOG2_MAX = ((1 << $clog2(SETS)) > SETS) ? $clog2(SETS) - 1
                                                              : $clog2(SETS);
  localparam int RANK_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_ROW_W    = WAYS * ADDR_BITS;
  localparam int VM_ROW_W     = WAYS * VM_W;
  localparam int ENT_ROW_W    = TAG_ROW_W + VM_ROW_W;
  localparam int RANK_ROW_W   = WAYS * RANK_W;

  // Registers
  logic [LINE_SHIFT_W-1:0] line_shift_r;
  logic [SET_LOG2_W-1:0]   set_log2_r;
  logic [WAYS_CFG_W-1:0]   ways_r;

  // Request stage
  logic                    a_valid_r;
  kind_t                   a_kind_r;
  logic [ADDR_BITS-1:0]    a_line_r;
  logic [VM_W-1:0]         a_vm_r;
  logic [SET_W-1:0]        a_set_r;
  logic                    a_fwd_r;

  // Forwarded row of the last write-back
  logic [WAYS-1:0][ADDR_BITS-1:0] fwd_tag_r;
  logic [WAYS-1:0][VM_W-1:0]      fwd_vm_r;
  logic [WAYS-1:0][RANK_W-1:0]    fwd_rank_r;

  // Valid bits
  logic [SETS-1:0][WAYS-1:0] way_valid_r;
  logic [SETS-1:0]           rank_live_r;

  // Result register
  logic out_valid_r;
  logic out_hit_r;

  logic                 in_fire;
  logic                 a_fire;
  logic                 a_write;
  logic [ADDR_BITS-1:0] in_line;
  logic [SET_W-1:0]     set_mask;
  logic [SET_W-1:0]     in_set;
  logic [WAYS-1:0]      way_en;

  logic [ENT_ROW_W-1:0]  ent_rdata;
  logic [RANK_ROW_W-1:0] rank_rdata;

  logic [WAYS-1:0][ADDR_BITS-1:0] rd_tag;
  logic [WAYS-1:0][VM_W-1:0]      rd_vm;
  logic [WAYS-1:0][RANK_W-1:0]    rd_rank;
  logic [WAYS-1:0][RANK_W-1:0]    ident_rank;
  logic [WAYS-1:0][ADDR_BITS-1:0] cur_tag;
  logic [WAYS-1:0][VM_W-1:0]      cur_vm;
  logic [WAYS-1:0][RANK_W-1:0]    cur_rank;
  logic [WAYS-1:0]                cur_valid;

  logic [WAYS-1:0]                upd_valid_nxt;
  logic [WAYS-1:0][ADDR_BITS-1:0] upd_tag_nxt;
  logic [WAYS-1:0][VM_W-1:0]      upd_vm_nxt;
  logic [WAYS-1:0][RANK_W-1:0]    upd_rank_nxt;
  upd_stat_t                      upd_stat;

  // Handshakes
  assign a_fire       = a_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !a_valid_r || a_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign a_write      = a_fire && upd_stat.write;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_shift_r <= LINE_SHIFT_RST;
      set_log2_r   <= SET_LOG2_RST;
      ways_r       <= WAYS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_LINE_SHIFT: line_shift_r <= cfg_ch.wdata[LINE_SHIFT_W-1:0];
        CFG_SET_LOG2:   set_log2_r   <= cfg_ch.wdata[SET_LOG2_W-1:0];
        CFG_WAYS:       ways_r       <= cfg_ch.wdata[WAYS_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Line number and set of an incoming request
  assign in_line = in_ch.address >> line_shift_r;

  always_comb begin
    for (int b = 0; b < SET_W; b++) begin
      set_mask[b] = (b < int'(set_log2_r)) && (b < SET_LOG2_MAX);
    end
  end

  assign in_set = in_line[SET_W-1:0] & set_mask;

  // Ways in use: zero acts as one, above WAYS acts as WAYS
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_en[w] = (w == 0) || (w < int'(ways_r));
    end
  end

  // Request stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (a_fire) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_kind_r   <= kind_t'(in_ch.kind);
      a_line_r   <= in_line;
      a_vm_r     <= in_ch.vm_id;
      a_set_r    <= in_set;
      a_fwd_r    <= a_write && (in_set == a_set_r);
      fwd_tag_r  <= upd_tag_nxt;
      fwd_vm_r   <= upd_vm_nxt;
      fwd_rank_r <= upd_rank_nxt;
    end
  end

  // Tag/VM rows and rank rows
  satag_ram #(
    .WIDTH (ENT_ROW_W),
    .DEPTH (SETS)
  ) u_ent_ram (
    .clk   (clk),
    .we    (a_write),
    .waddr (a_set_r),
    .wdata ({upd_vm_nxt, upd_tag_nxt}),
    .re    (in_fire),
    .raddr (in_set),
    .rdata (ent_rdata)
  );

  satag_ram #(
    .WIDTH (RANK_ROW_W),
    .DEPTH (SETS)
  ) u_rank_ram (
    .clk   (clk),
    .we    (a_write),
    .waddr (a_set_r),
    .wdata (upd_rank_nxt),
    .re    (in_fire),
    .raddr (in_set),
    .rdata (rank_rdata)
  );

  assign rd_tag  = ent_rdata[TAG_ROW_W-1:0];
  assign rd_vm   = ent_rdata[ENT_ROW_W-1:TAG_ROW_W];
  assign rd_rank = rank_rdata;

  // Reset rank order: each way ranked by its index
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ident_rank[w] = RANK_W'(w);
    end
  end

  // Current row: forwarded write-back, RAM data, or reset ranks
  always_comb begin
    cur_valid = way_valid_r[a_set_r];
    if (a_fwd_r) begin
      cur_tag  = fwd_tag_r;
      cur_vm   = fwd_vm_r;
      cur_rank = fwd_rank_r;
    end else begin
      cur_tag  = rd_tag;
      cur_vm   = rd_vm;
      cur_rank = rank_live_r[a_set_r] ? rd_rank : ident_rank;
    end
  end

  satag_update #(
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_update (
    .kind      (a_kind_r),
    .line      (a_line_r),
    .vm        (a_vm_r),
    .way_en    (way_en),
    .valid_row (cur_valid),
    .tag_row   (cur_tag),
    .vm_row    (cur_vm),
    .rank_row  (cur_rank),
    .valid_nxt (upd_valid_nxt),
    .tag_nxt   (upd_tag_nxt),
    .vm_nxt    (upd_vm_nxt),
    .rank_nxt  (upd_rank_nxt),
    .stat      (upd_stat)
  );

  // Valid bits: invalidate-all clears everything at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      way_valid_r <= '0;
      rank_live_r <= '0;
    end else if (a_fire && a_kind_r == KIND_INVAL_ALL) begin
      way_valid_r <= '0;
      rank_live_r <= '0;
    end else if (a_write) begin
      way_valid_r[a_set_r] <= upd_valid_nxt;
      rank_live_r[a_set_r] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      out_hit_r <= upd_stat.hit;
    end
  end

  // Checks
  `SATAG_ASSERT_NEXT(a_inval_all_clears, a_fire && a_kind_r == KIND_INVAL_ALL, way_valid_r == '0 && rank_live_r == '0, "invalidate-all left a valid way")
  `SATAG_ASSERT_NEXT(a_inval_all_no_hit, a_fire && a_kind_r == KIND_INVAL_ALL, !out_hit_r, "invalidate-all reported a hit")
  `SATAG_ASSERT_NEXT(a_probe_keeps_state, a_fire && a_kind_r == KIND_PROBE, $stable(way_valid_r) && $stable(rank_live_r), "probe changed the valid bits")
  `SATAG_ASSERT_NEXT(a_inval_frees_way, a_fire && a_kind_r == KIND_INVAL && upd_stat.hit, way_valid_r != $past(way_valid_r), "invalidate hit freed no way")
  `SATAG_ASSERT_SAME(a_result_from_stage, $rose(out_valid_r), $past(a_fire), "result beat without a completed request")

endmodule
